/* rtl/tedf_pkg.sv */
// Shared types, constants and field codes of the touch event debounce filter.
package tedf_pkg;

   localparam int COORD_BITS  = 12;
   localparam int RAW_BITS    = 16;
   localparam int DIM_BITS    = 13;
   localparam int TIME_BITS   = 32;
   localparam int HOLD_BITS   = 16;
   localparam int COUNT_BITS  = 4;
   localparam int STATUS_BITS = 8;
   localparam int ORIENT_BITS = 3;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 16;

   localparam int MAX_POINTS   = 5;
   localparam int NEW_DATA_BIT = 7;

   localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(4096);
   localparam logic [DIM_BITS-1:0] DIM_MIN = DIM_BITS'(1);

   localparam logic [ORIENT_BITS-1:0] ORIENT_RST   = '0;
   localparam logic [DIM_BITS-1:0]    WIDTH_RST    = DIM_BITS'(800);
   localparam logic [DIM_BITS-1:0]    HEIGHT_RST   = DIM_BITS'(480);
   localparam logic [COORD_BITS-1:0]  DRIFT_RST    = COORD_BITS'(8);
   localparam logic [HOLD_BITS-1:0]   PRESS_RST    = HOLD_BITS'(20);
   localparam logic [HOLD_BITS-1:0]   RELEASE_RST  = HOLD_BITS'(30);
   localparam logic [COORD_BITS-1:0]  STEP_RST     = COORD_BITS'(2);
   localparam logic [HOLD_BITS-1:0]   PERIOD_RST   = HOLD_BITS'(50);

   typedef enum logic [1:0] {
      RR_OK          = 2'd0,
      RR_STATUS_FAIL = 2'd1,
      RR_POINT_FAIL  = 2'd2,
      RR_UNUSED      = 2'd3
   } read_result_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_MOVE    = 2'd2,
      EV_RELEASE = 2'd3
   } event_kind_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ORIENTATION  = 3'd0,
      CSR_SCREEN_W     = 3'd1,
      CSR_SCREEN_H     = 3'd2,
      CSR_DRIFT_LIMIT  = 3'd3,
      CSR_PRESS_HOLD   = 3'd4,
      CSR_RELEASE_HOLD = 3'd5,
      CSR_MOVE_STEP    = 3'd6,
      CSR_MOVE_PERIOD  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [ORIENT_BITS-1:0] orientation;
      logic [DIM_BITS-1:0]    screen_width;
      logic [DIM_BITS-1:0]    screen_height;
      logic [COORD_BITS-1:0]  drift_limit;
      logic [HOLD_BITS-1:0]   press_hold_ms;
      logic [HOLD_BITS-1:0]   release_hold_ms;
      logic [COORD_BITS-1:0]  move_step;
      logic [HOLD_BITS-1:0]   move_period_ms;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] touch_status;
      logic [RAW_BITS-1:0]    raw_x;
      logic [RAW_BITS-1:0]    raw_y;
      logic [TIME_BITS-1:0]   now_ms;
      read_result_type        read_result;
   } item_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  on_screen;
   } point_type;

   typedef struct packed {
      event_kind_type        event_kind;
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
      logic                  is_pressed;
      logic                  in_range;
      logic [COUNT_BITS-1:0] touch_count;
      logic                  clear_request;
      logic                  halted;
   } result_type;

endpackage

/* rtl/tedf_map.sv */
// Screen mapping: swap, mirror and clamp of a raw touch point.
module tedf_map (
   input  logic [tedf_pkg::RAW_BITS-1:0]    raw_x,
   input  logic [tedf_pkg::RAW_BITS-1:0]    raw_y,
   input  logic [tedf_pkg::ORIENT_BITS-1:0] orientation,
   input  logic [tedf_pkg::DIM_BITS-1:0]    screen_width,
   input  logic [tedf_pkg::DIM_BITS-1:0]    screen_height,
   output tedf_pkg::point_type              point
);

   logic [tedf_pkg::DIM_BITS-1:0] w_eff;
   logic [tedf_pkg::DIM_BITS-1:0] h_eff;
   logic [tedf_pkg::RAW_BITS-1:0] w_ext;
   logic [tedf_pkg::RAW_BITS-1:0] h_ext;
   logic [tedf_pkg::RAW_BITS-1:0] sx;
   logic [tedf_pkg::RAW_BITS-1:0] sy;
   logic [tedf_pkg::RAW_BITS-1:0] mx;
   logic [tedf_pkg::RAW_BITS-1:0] my;
   logic                          x_on;
   logic                          y_on;

   // Zero acts as one pixel, anything above the maximum acts as the maximum
   always_comb begin
      w_eff = screen_width;
      if (screen_width == '0) begin
         w_eff = tedf_pkg::DIM_MIN;
      end else if (screen_width > tedf_pkg::DIM_MAX) begin
         w_eff = tedf_pkg::DIM_MAX;
      end
      h_eff = screen_height;
      if (screen_height == '0) begin
         h_eff = tedf_pkg::DIM_MIN;
      end else if (screen_height > tedf_pkg::DIM_MAX) begin
         h_eff = tedf_pkg::DIM_MAX;
      end
   end

   assign w_ext = tedf_pkg::RAW_BITS'(w_eff);
   assign h_ext = tedf_pkg::RAW_BITS'(h_eff);

   always_comb begin
      sx = orientation[0] ? raw_y : raw_x;
      sy = orientation[0] ? raw_x : raw_y;
      mx = sx;
      my = sy;
      if (orientation[1] && (sx < w_ext)) begin
         mx = w_ext - 16'd1 - sx;
      end
      if (orientation[2] && (sy < h_ext)) begin
         my = h_ext - 16'd1 - sy;
      end
      x_on = mx < w_ext;
      y_on = my < h_ext;
      point.on_screen = x_on && y_on;
      point.x = x_on ? mx[tedf_pkg::COORD_BITS-1:0]
                     : w_ext[tedf_pkg::COORD_BITS-1:0] - 12'd1;
      point.y = y_on ? my[tedf_pkg::COORD_BITS-1:0]
                     : h_ext[tedf_pkg::COORD_BITS-1:0] - 12'd1;
   end

endmodule

/* rtl/tedf_track.sv */
// Press, move and release debounce state and its per-item update.
module tedf_track (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tedf_pkg::item_type    item,
   input  tedf_pkg::point_type   point,
   input  tedf_pkg::cfg_type     cfg,
   output tedf_pkg::result_type  result
);

   typedef struct packed {
      logic                                stopped;
      logic                                down;
      logic                                press_pending;
      logic [tedf_pkg::TIME_BITS-1:0]      press_since;
      logic [tedf_pkg::COORD_BITS-1:0]     anchor_x;
      logic [tedf_pkg::COORD_BITS-1:0]     anchor_y;
      logic                                release_pending;
      logic [tedf_pkg::TIME_BITS-1:0]      release_since;
      logic [tedf_pkg::COORD_BITS-1:0]     reported_x;
      logic [tedf_pkg::COORD_BITS-1:0]     reported_y;
      logic [tedf_pkg::TIME_BITS-1:0]      move_time;
      logic [tedf_pkg::COORD_BITS-1:0]     shown_x;
      logic [tedf_pkg::COORD_BITS-1:0]     shown_y;
      logic                                valid_flag;
      logic [tedf_pkg::COUNT_BITS-1:0]     count_seen;
   } track_state_type;

   track_state_type st_ff;
   track_state_type st_in;

   function automatic logic [tedf_pkg::COORD_BITS-1:0] absdiff(
      input logic [tedf_pkg::COORD_BITS-1:0] a,
      input logic [tedf_pkg::COORD_BITS-1:0] b
   );
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [tedf_pkg::COUNT_BITS-1:0] cnt;
   logic                            new_data;
   logic                            cnt_ok;
   logic                            touch;
   logic                            rr_good;
   logic [tedf_pkg::TIME_BITS-1:0]  press_age;
   logic [tedf_pkg::TIME_BITS-1:0]  release_age;
   logic [tedf_pkg::TIME_BITS-1:0]  move_age;
   logic                            drifted;
   logic                            moved;
   tedf_pkg::event_kind_type        kind;
   logic                            clr;

   assign cnt      = item.touch_status[tedf_pkg::COUNT_BITS-1:0];
   assign new_data = item.touch_status[tedf_pkg::NEW_DATA_BIT];
   assign cnt_ok   = cnt <= tedf_pkg::COUNT_BITS'(tedf_pkg::MAX_POINTS);
   assign touch    = new_data && cnt_ok && (cnt != '0);
   assign rr_good  = (item.read_result == tedf_pkg::RR_OK) ||
                     (item.read_result == tedf_pkg::RR_POINT_FAIL);

   // Time differences wrap modulo 2^32
   assign press_age   = item.now_ms - st_ff.press_since;
   assign release_age = item.now_ms - st_ff.release_since;
   assign move_age    = item.now_ms - st_ff.move_time;

   assign drifted = (absdiff(point.x, st_ff.anchor_x) > cfg.drift_limit) ||
                    (absdiff(point.y, st_ff.anchor_y) > cfg.drift_limit);
   assign moved   = (absdiff(point.x, st_ff.reported_x) >= cfg.move_step) ||
                    (absdiff(point.y, st_ff.reported_y) >= cfg.move_step) ||
                    (move_age >= tedf_pkg::TIME_BITS'(cfg.move_period_ms));

   always_comb begin
      st_in = st_ff;
      kind  = tedf_pkg::EV_NONE;
      clr   = 1'b0;
      if (!st_ff.stopped) begin
         if (!rr_good) begin
            st_in.stopped = 1'b1;
         end else begin
            st_in.count_seen = cnt;
            clr = new_data && cnt_ok;
            if (touch) begin
               if (item.read_result == tedf_pkg::RR_POINT_FAIL) begin
                  st_in.stopped = 1'b1;
               end else begin
                  st_in.valid_flag = point.on_screen;
                  st_in.shown_x    = point.x;
                  st_in.shown_y    = point.y;
                  if (!st_ff.down) begin
                     st_in.release_pending = 1'b0;
                     st_in.release_since   = '0;
                     if (!st_ff.press_pending || drifted) begin
                        // restart the candidate at this point
                        st_in.anchor_x      = point.x;
                        st_in.anchor_y      = point.y;
                        st_in.press_since   = item.now_ms;
                        st_in.press_pending = 1'b1;
                     end else if (press_age >=
                                  tedf_pkg::TIME_BITS'(cfg.press_hold_ms)) begin
                        kind                = tedf_pkg::EV_PRESS;
                        st_in.down          = 1'b1;
                        st_in.reported_x    = point.x;
                        st_in.reported_y    = point.y;
                        st_in.move_time     = item.now_ms;
                        st_in.press_pending = 1'b0;
                     end
                  end else begin
                     st_in.press_pending   = 1'b0;
                     st_in.press_since     = '0;
                     st_in.release_pending = 1'b0;
                     st_in.release_since   = '0;
                     if (moved) begin
                        kind             = tedf_pkg::EV_MOVE;
                        st_in.reported_x = point.x;
                        st_in.reported_y = point.y;
                        st_in.move_time  = item.now_ms;
                     end
                  end
               end
            end else if (st_ff.down) begin
               if (!st_ff.release_pending) begin
                  st_in.release_pending = 1'b1;
                  st_in.release_since   = item.now_ms;
               end else if (release_age >=
                            tedf_pkg::TIME_BITS'(cfg.release_hold_ms)) begin
                  kind                  = tedf_pkg::EV_RELEASE;
                  st_in.down            = 1'b0;
                  st_in.shown_x         = st_ff.reported_x;
                  st_in.shown_y         = st_ff.reported_y;
                  st_in.valid_flag      = 1'b1;
                  st_in.release_pending = 1'b0;
                  st_in.release_since   = '0;
               end
            end else begin
               st_in.press_pending = 1'b0;
               st_in.press_since   = '0;
            end
         end
      end
   end

   always_comb begin
      result.event_kind    = kind;
      result.point_x       = st_in.shown_x;
      result.point_y       = st_in.shown_y;
      result.is_pressed    = st_in.down;
      result.in_range      = st_in.valid_flag;
      result.touch_count   = st_in.count_seen;
      result.clear_request = clr;
      result.halted        = st_in.stopped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (step) begin
         st_ff <= st_in;
      end
   end

`ifndef SYNTH
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      st_ff.stopped |=> st_ff.stopped)
      else $error("halt state cleared without reset");

   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && st_ff.stopped) |-> (result.event_kind == tedf_pkg::EV_NONE && !clr))
      else $error("event or clear reported while halted");

   a_no_pending_when_down: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.down && st_ff.press_pending))
      else $error("press candidate open while pressed");

   a_release_lifts: assert property (@(posedge clock) disable iff (reset)
      (step && result.event_kind == tedf_pkg::EV_RELEASE) |=> !st_ff.down)
      else $error("still pressed after release");

   a_press_sets: assert property (@(posedge clock) disable iff (reset)
      (step && result.event_kind == tedf_pkg::EV_PRESS) |=>
      (st_ff.down && st_ff.reported_x == st_ff.shown_x))
      else $error("press did not latch down state and point");
`endif

endmodule

/* rtl/touch_event_debounce_filter_core.sv */
// Top level of the touch event debounce filter: ports, settings, item and result registers.
//
// Each request item is one poll of a touch controller; each poll yields exactly one
// response item. The poll's point is swapped/mirrored per orientation, clamped to the
// screen, and debounced into press, move and release events (kind in rsp_tuser).
// Throughput is one item per clock while the consumer does not stall: an accepted item
// waits in the input register, the mapping and debounce update run as one combinational
// pass against the tracker state, and the result lands in the response register. The
// input register refills while a finished response still waits, so a stalled consumer
// costs throughput only once both registers are full. A read failure halts the block
// until reset; halted polls still return a response holding the frozen state. Write
// settings over the csr_ port only while no item is in flight. Reset is synchronous
// and clears state and settings to defaults.
module touch_event_debounce_filter_core (
   input  logic        clock,
   input  logic        reset,
   // Request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // touch_status[7:0], raw_x[23:8], raw_y[39:24], now_ms[71:40]
   input  logic [1:0]  req_tuser,  // read_result[1:0]
   // Response items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // point_x[11:0], point_y[23:12], is_pressed[24],
                                   // in_range[25], touch_count[29:26], clear_request[30],
                                   // halted[31]
   output logic [1:0]  rsp_tuser,  // event_kind[1:0]
   // Settings write port
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   tedf_pkg::cfg_type    cfg_ff;
   tedf_pkg::item_type   item_ff;
   logic                 item_valid_ff;
   tedf_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   tedf_pkg::point_type  point;
   tedf_pkg::result_type result;
   logic                 advance;
   logic                 take;

   // Process the held item once the response register is free or draining
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation     <= tedf_pkg::ORIENT_RST;
         cfg_ff.screen_width    <= tedf_pkg::WIDTH_RST;
         cfg_ff.screen_height   <= tedf_pkg::HEIGHT_RST;
         cfg_ff.drift_limit     <= tedf_pkg::DRIFT_RST;
         cfg_ff.press_hold_ms   <= tedf_pkg::PRESS_RST;
         cfg_ff.release_hold_ms <= tedf_pkg::RELEASE_RST;
         cfg_ff.move_step       <= tedf_pkg::STEP_RST;
         cfg_ff.move_period_ms  <= tedf_pkg::PERIOD_RST;
      end else if (csr_wen) begin
         case (tedf_pkg::csr_index_type'(csr_addr))
            tedf_pkg::CSR_ORIENTATION: begin
               cfg_ff.orientation <= csr_wdata[tedf_pkg::ORIENT_BITS-1:0];
            end
            tedf_pkg::CSR_SCREEN_W: begin
               cfg_ff.screen_width <= csr_wdata[tedf_pkg::DIM_BITS-1:0];
            end
            tedf_pkg::CSR_SCREEN_H: begin
               cfg_ff.screen_height <= csr_wdata[tedf_pkg::DIM_BITS-1:0];
            end
            tedf_pkg::CSR_DRIFT_LIMIT: begin
               cfg_ff.drift_limit <= csr_wdata[tedf_pkg::COORD_BITS-1:0];
            end
            tedf_pkg::CSR_PRESS_HOLD: begin
               cfg_ff.press_hold_ms <= csr_wdata[tedf_pkg::HOLD_BITS-1:0];
            end
            tedf_pkg::CSR_RELEASE_HOLD: begin
               cfg_ff.release_hold_ms <= csr_wdata[tedf_pkg::HOLD_BITS-1:0];
            end
            tedf_pkg::CSR_MOVE_STEP: begin
               cfg_ff.move_step <= csr_wdata[tedf_pkg::COORD_BITS-1:0];
            end
            tedf_pkg::CSR_MOVE_PERIOD: begin
               cfg_ff.move_period_ms <= csr_wdata[tedf_pkg::HOLD_BITS-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Input register: hold the item until it has been processed
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (take) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.touch_status <= req_tdata[7:0];
         item_ff.raw_x        <= req_tdata[23:8];
         item_ff.raw_y        <= req_tdata[39:24];
         item_ff.now_ms       <= req_tdata[71:40];
         item_ff.read_result  <= tedf_pkg::read_result_type'(req_tuser);
      end
   end

   tedf_map u_map (
      .raw_x         (item_ff.raw_x),
      .raw_y         (item_ff.raw_y),
      .orientation   (cfg_ff.orientation),
      .screen_width  (cfg_ff.screen_width),
      .screen_height (cfg_ff.screen_height),
      .point         (point)
   );

   tedf_track u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .point  (point),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.event_kind;
   assign rsp_tdata  = {rsp_ff.halted, rsp_ff.clear_request, rsp_ff.touch_count,
                        rsp_ff.in_range, rsp_ff.is_pressed, rsp_ff.point_y,
                        rsp_ff.point_x};

endmodule
